### hdl/aarf_pkg.sv
package aarf_pkg;

   localparam int unsigned DATA_W  = 32;
   localparam int unsigned ADDR_W  = 14;
   localparam int unsigned OFS_W   = 12;
   localparam int unsigned IDX_W   = 10;
   localparam int unsigned ALIAS_W = 2;

   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   localparam logic [ALIAS_W-1:0] ALIAS_PLAIN = 2'd0;
   localparam logic [ALIAS_W-1:0] ALIAS_XOR   = 2'd1;
   localparam logic [ALIAS_W-1:0] ALIAS_SET   = 2'd2;
   localparam logic [ALIAS_W-1:0] ALIAS_CLEAR = 2'd3;

   localparam logic [OFS_W-1:0] OFS_STATUS    = 12'h050;
   localparam logic [OFS_W-1:0] OFS_IRQ_RAW   = 12'h08c;
   localparam logic [OFS_W-1:0] OFS_IRQ_EN    = 12'h090;
   localparam logic [OFS_W-1:0] OFS_IRQ_FORCE = 12'h094;
   localparam logic [OFS_W-1:0] OFS_IRQ_STAT  = 12'h098;

   localparam logic [IDX_W-1:0] IDX_IRQ_RAW   = OFS_IRQ_RAW[OFS_W-1:2];
   localparam logic [IDX_W-1:0] IDX_IRQ_EN    = OFS_IRQ_EN[OFS_W-1:2];
   localparam logic [IDX_W-1:0] IDX_IRQ_FORCE = OFS_IRQ_FORCE[OFS_W-1:2];

   localparam logic [DATA_W-1:0] POWER_DETECTED = 32'h0000_0800;

   function automatic logic [DATA_W-1:0] combine_word(
      input logic [DATA_W-1:0]  old_word,
      input logic [DATA_W-1:0]  val,
      input logic [ALIAS_W-1:0] alias_sel
   );
      logic [DATA_W-1:0] res;
      case (alias_sel)
         ALIAS_PLAIN: res = val;
         ALIAS_XOR:   res = old_word ^ val;
         ALIAS_SET:   res = old_word | val;
         ALIAS_CLEAR: res = old_word & ~val;
         default:     res = val;
      endcase
      return res;
   endfunction

endpackage

### hdl/aarf_ram.sv
module aarf_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/aarf_clear.sv
module aarf_clear #(
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   output logic                     busy,
   output logic [$clog2(DEPTH)-1:0] addr
);

   localparam int unsigned AW = $clog2(DEPTH);
   localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

   logic          busy_ff, busy_in;
   logic [AW-1:0] idx_ff, idx_in;

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (busy_ff) begin
         idx_in = idx_ff + AW'(1);
         if (idx_ff == LAST) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   assign busy = busy_ff;
   assign addr = idx_ff;

endmodule

### hdl/atomic_alias_register_file_top.sv
// a read word passes through stage one and then the rsp register; writes give no word
// throughput: one access per cycle while req_stall is low, set by the read-modify-write on the ram port
// an access to the word that the last write wrote is served from a forwarding register
// reset: synchronous; afterwards a clearing pass writes zero to every word,
// with req_stall held high until it ends
module atomic_alias_register_file_top #(
   parameter int unsigned REG_WORDS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [13:0] req_addr,
   input  logic [31:0] req_wdata,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_rdata
);

   localparam int unsigned AW = $clog2(REG_WORDS);
   localparam int unsigned DW = aarf_pkg::DATA_W;
   localparam int unsigned IW = aarf_pkg::IDX_W;
   localparam logic [IW:0] WORD_LIMIT = (IW + 1)'(REG_WORDS);

   logic accept;

   // stage one
   logic                        s1_valid_ff, s1_valid_in;
   logic                        s1_op_ff;
   logic [aarf_pkg::OFS_W-1:0]  s1_ofs_ff;
   logic [aarf_pkg::ALIAS_W-1:0] s1_alias_ff;
   logic [DW-1:0]               s1_wdata_ff;
   logic                        s1_advance;

   // forwarding of the last write
   logic          fwd_valid_ff, fwd_valid_in;
   logic [IW-1:0] fwd_idx_ff, fwd_idx_in;
   logic [DW-1:0] fwd_data_ff, fwd_data_in;

   // copies of the interrupt words
   logic [DW-1:0] irq_raw_ff, irq_raw_in;
   logic [DW-1:0] irq_en_ff, irq_en_in;
   logic [DW-1:0] irq_force_ff, irq_force_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0] rsp_rdata_ff, rsp_rdata_in;
   logic          out_load;

   logic [IW-1:0] s1_idx;
   logic          s1_hit;
   logic [DW-1:0] ram_rdata;
   logic [DW-1:0] old_word;
   logic [DW-1:0] new_word;
   logic [DW-1:0] read_word;
   logic          do_write;

   logic          clr_busy;
   logic [AW-1:0] clr_addr;

   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   logic [DW-1:0] ram_wr_data;
   logic [IW-1:0] req_idx;

   aarf_clear #(
      .DEPTH (REG_WORDS)
   ) u_clear (
      .clock (clock),
      .reset (reset),
      .busy  (clr_busy),
      .addr  (clr_addr)
   );

   assign req_idx = req_addr[aarf_pkg::OFS_W-1:2];

   aarf_ram #(
      .WIDTH (DW),
      .DEPTH (REG_WORDS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (accept),
      .rd_addr (req_idx[AW-1:0]),
      .rd_data (ram_rdata)
   );

   assign out_load   = !rsp_valid_ff || !rsp_stall;
   assign s1_advance = !s1_valid_ff || (s1_op_ff == aarf_pkg::OP_WRITE) || out_load;
   assign req_stall  = clr_busy || (s1_valid_ff && !s1_advance);
   assign accept     = req_valid && !req_stall;

   assign s1_idx   = s1_ofs_ff[aarf_pkg::OFS_W-1:2];
   assign s1_hit   = {1'b0, s1_idx} < WORD_LIMIT;
   assign old_word = (fwd_valid_ff && (fwd_idx_ff == s1_idx)) ? fwd_data_ff : ram_rdata;
   assign new_word = aarf_pkg::combine_word(old_word, s1_wdata_ff, s1_alias_ff);
   assign do_write = s1_valid_ff && (s1_op_ff == aarf_pkg::OP_WRITE) && s1_hit;

   always_comb begin
      if (s1_ofs_ff == aarf_pkg::OFS_STATUS) begin
         read_word = old_word | aarf_pkg::POWER_DETECTED;
      end else if (s1_ofs_ff == aarf_pkg::OFS_IRQ_STAT) begin
         read_word = (irq_raw_ff | irq_force_ff) & irq_en_ff;
      end else if (s1_hit) begin
         read_word = old_word;
      end else begin
         read_word = '0;
      end
   end

   always_comb begin
      if (clr_busy) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_addr;
         ram_wr_data = '0;
      end else begin
         ram_wr_en   = do_write;
         ram_wr_addr = s1_idx[AW-1:0];
         ram_wr_data = new_word;
      end
   end

   always_comb begin
      s1_valid_in  = s1_advance ? accept : s1_valid_ff;
      fwd_valid_in = fwd_valid_ff;
      fwd_idx_in   = fwd_idx_ff;
      fwd_data_in  = fwd_data_ff;
      irq_raw_in   = irq_raw_ff;
      irq_en_in    = irq_en_ff;
      irq_force_in = irq_force_ff;
      if (do_write) begin
         fwd_valid_in = 1'b1;
         fwd_idx_in   = s1_idx;
         fwd_data_in  = new_word;
         if (s1_idx == aarf_pkg::IDX_IRQ_RAW) begin
            irq_raw_in = new_word;
         end
         if (s1_idx == aarf_pkg::IDX_IRQ_EN) begin
            irq_en_in = new_word;
         end
         if (s1_idx == aarf_pkg::IDX_IRQ_FORCE) begin
            irq_force_in = new_word;
         end
      end
      rsp_valid_in = rsp_valid_ff;
      rsp_rdata_in = rsp_rdata_ff;
      if (out_load) begin
         rsp_valid_in = s1_valid_ff && (s1_op_ff == aarf_pkg::OP_READ);
         rsp_rdata_in = read_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         irq_raw_ff   <= '0;
         irq_en_ff    <= '0;
         irq_force_ff <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         fwd_valid_ff <= fwd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         irq_raw_ff   <= irq_raw_in;
         irq_en_ff    <= irq_en_in;
         irq_force_ff <= irq_force_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff    <= req_op;
         s1_ofs_ff   <= req_addr[aarf_pkg::OFS_W-1:0];
         s1_alias_ff <= req_addr[aarf_pkg::ADDR_W-1:aarf_pkg::OFS_W];
         s1_wdata_ff <= req_wdata;
      end
      fwd_idx_ff   <= fwd_idx_in;
      fwd_data_ff  <= fwd_data_in;
      rsp_rdata_ff <= rsp_rdata_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_rdata = rsp_rdata_ff;

   a_clear_after_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> clr_busy)
      else $error("clearing pass not started after reset");

   a_empty_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clr_busy |-> !s1_valid_ff && !rsp_valid_ff)
      else $error("access in flight during clearing pass");

   a_word_from_read: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff && (s1_op_ff == aarf_pkg::OP_READ)))
      else $error("result word without a read");

   a_write_never_held: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && (s1_op_ff == aarf_pkg::OP_WRITE) |=> !$past(req_stall) || !clr_busy)
      else $error("write held in stage one");

endmodule
